### design/sks_pkg.sv
// Shared types and codes for the sorted key set unit.
`default_nettype none

package sks_pkg;

  localparam int unsigned KeyWidth    = 32;
  localparam int unsigned StatusWidth = 3;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DELETE    = 2'd1,
    OP_LIST_ASC  = 2'd2,
    OP_LIST_DESC = 2'd3
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_LIST_RD,
    S_LIST_OUT,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_CNT,
    IDX_CNT_M1,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1
  } rd_sel_e;

  typedef struct packed {
    logic    latch;
    idx_op_e idx_op;
    logic    pos_save;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_key;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    logic    out_item;
    status_e out_status;
    logic    out_last;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic cnt_zero;
    logic full;
    logic idx_at_end;
    logic idx_at_pos;
    logic idx_next_end;
    logic key_eq;
    logic entry_gt;
    logic list_final;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### design/sks_ctrl.sv
// Sequencing state machine for the sorted key set unit.
`default_nettype none

module sks_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire sks_pkg::dp_sts_t sts_i,
  output sks_pkg::dp_cmd_t     cmd_o
);
  import sks_pkg::*;

  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    st_d           = st_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.idx_op   = IDX_HOLD;
    cmd_o.rd_sel   = RD_IDX;
    cmd_o.out_status = st_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (sts_i.op)
          OP_INSERT: begin
            cmd_o.idx_op = IDX_ZERO;
            state_d      = S_SRCH_RD;
          end
          OP_DELETE: begin
            if (sts_i.cnt_zero) begin
              st_d    = ST_EMPTY;
              state_d = S_RESP;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_SRCH_RD;
            end
          end
          default: begin
            if (sts_i.cnt_zero) begin
              st_d    = ST_EMPTY;
              state_d = S_RESP;
            end else begin
              cmd_o.idx_op = (sts_i.op == OP_LIST_ASC) ? IDX_ZERO : IDX_CNT_M1;
              state_d      = S_LIST_RD;
            end
          end
        endcase
      end

      S_SRCH_RD: begin
        if (sts_i.idx_at_end) begin
          if (sts_i.op == OP_INSERT) begin
            cmd_o.pos_save = 1'b1;
            if (sts_i.full) begin
              st_d    = ST_FULL;
              state_d = S_RESP;
            end else begin
              cmd_o.idx_op = IDX_CNT;
              state_d      = S_INS_RD;
            end
          end else begin
            st_d    = ST_NOT_FOUND;
            state_d = S_RESP;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        if (sts_i.op == OP_INSERT) begin
          if (sts_i.key_eq) begin
            st_d    = ST_DUP;
            state_d = S_RESP;
          end else if (sts_i.entry_gt) begin
            cmd_o.pos_save = 1'b1;
            if (sts_i.full) begin
              st_d    = ST_FULL;
              state_d = S_RESP;
            end else begin
              cmd_o.idx_op = IDX_CNT;
              state_d      = S_INS_RD;
            end
          end else begin
            cmd_o.idx_op = IDX_INC;
            state_d      = S_SRCH_RD;
          end
        end else begin
          if (sts_i.key_eq) begin
            state_d = S_DEL_RD;
          end else begin
            cmd_o.idx_op = IDX_INC;
            state_d      = S_SRCH_RD;
          end
        end
      end

      // shift entries up by one, top down, then drop the key into the gap
      S_INS_RD: begin
        if (sts_i.idx_at_pos) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_key  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          st_d          = ST_OK;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_M1;
          state_d      = S_INS_WR;
        end
      end

      S_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_INS_RD;
      end

      // close the gap: shift entries above the hit down by one
      S_DEL_RD: begin
        if (sts_i.idx_next_end) begin
          cmd_o.cnt_dec = 1'b1;
          st_d          = ST_OK;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_P1;
          state_d      = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_DEL_RD;
      end

      S_LIST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_item   = 1'b1;
          cmd_o.out_status = ST_OK;
          cmd_o.out_last   = sts_i.list_final;
          if (sts_i.list_final) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = (sts_i.op == OP_LIST_ASC) ? IDX_INC : IDX_DEC;
            state_d      = S_LIST_RD;
          end
        end
      end

      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/sks_dp.sv
// Key store, index counters, comparator and result register.
`default_nettype none

module sks_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [1:0]                          op_i,
  input  wire logic signed [sks_pkg::KeyWidth-1:0] key_i,
  input  wire sks_pkg::dp_cmd_t                    cmd_i,
  output sks_pkg::dp_sts_t                         sts_o,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic [sks_pkg::StatusWidth-1:0]          status_o,
  output logic signed [sks_pkg::KeyWidth-1:0]      out_key_o,
  output logic                                     last_o
);
  import sks_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [KeyWidth-1:0] mem [CAPACITY];

  op_e                        op_q;
  logic signed [KeyWidth-1:0] key_q;
  logic signed [KeyWidth-1:0] rdata_q;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic [CW-1:0]              pos_q;
  logic [CW-1:0]              raddr_full;
  logic [AW-1:0]              raddr, waddr;
  logic signed [KeyWidth-1:0] wdata;

  logic                       out_valid_q;
  status_e                    out_status_q;
  logic signed [KeyWidth-1:0] out_key_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_e'(op_i);
      key_q <= key_i;
    end
    if (cmd_i.pos_save) begin
      pos_q <= idx_q;
    end
    idx_q <= idx_d;
  end

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_HOLD:   idx_d = idx_q;
      IDX_ZERO:   idx_d = '0;
      IDX_CNT:    idx_d = cnt_q;
      IDX_CNT_M1: idx_d = cnt_q - CW'(1);
      IDX_INC:    idx_d = idx_q + CW'(1);
      IDX_DEC:    idx_d = idx_q - CW'(1);
      default:    idx_d = idx_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // key store: one write and one registered read per cycle
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX_M1: raddr_full = idx_q - CW'(1);
      RD_IDX_P1: raddr_full = idx_q + CW'(1);
      default:   raddr_full = idx_q;
    endcase
  end

  assign raddr = raddr_full[AW-1:0];
  assign waddr = idx_q[AW-1:0];
  assign wdata = cmd_i.wr_key ? key_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_last_q   <= cmd_i.out_last;
      if (cmd_i.out_item) begin
        out_key_q <= rdata_q;
      end else if (op_q == OP_LIST_ASC || op_q == OP_LIST_DESC) begin
        out_key_q <= '0;
      end else begin
        out_key_q <= key_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_key_o   = out_key_q;
  assign last_o      = out_last_q;

  always_comb begin
    sts_o.op           = op_q;
    sts_o.cnt_zero     = (cnt_q == '0);
    sts_o.full         = (cnt_q == CW'(CAPACITY));
    sts_o.idx_at_end   = (idx_q == cnt_q);
    sts_o.idx_at_pos   = (idx_q == pos_q);
    sts_o.idx_next_end = ((idx_q + CW'(1)) == cnt_q);
    sts_o.key_eq       = (rdata_q == key_q);
    sts_o.entry_gt     = (rdata_q > key_q);
    sts_o.list_final   = (op_q == OP_LIST_ASC) ? (idx_q == (cnt_q - CW'(1)))
                                               : (idx_q == '0);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

### design/sorted_key_set_unit.sv
// Top level of the sorted key set unit: controller plus datapath.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o | op_i[1:0], key_i[31:0] signed
//   out     | output    | out_valid_o/out_ready_i | status_o[2:0], out_key_o, last_o
//
// One item at a time; all work goes through the read port and the write
// port of the key store, and each entry touched is read, then used.
// Reset clears the entry count, the result valid flag and the sequencer
// state; stored keys are don't-care until written. A stalled out transfer
// holds the sequencer.
`default_nettype none

module sorted_key_set_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          op_i,
  input  wire logic signed [sks_pkg::KeyWidth-1:0] key_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [sks_pkg::StatusWidth-1:0]          status_o,
  output logic signed [sks_pkg::KeyWidth-1:0]      out_key_o,
  output logic                                     last_o
);
  import sks_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: decodes the operation, walks the store, paces results
  sks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // key store, counters, compare and the result register
  sks_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op_i),
    .key_i       (key_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .out_key_o   (out_key_o),
    .last_o      (last_o)
  );

  // accepting a transfer always leaves the idle state
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

  // no insert into a full store
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !sts.full)
    else $error("entry count overflow");

  // no delete from an empty store
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_dec |-> !sts.cnt_zero)
    else $error("entry count underflow");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the sorted key set unit: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import sks_pkg::*;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned CYCLE_CAP  = 1_000_000;
  localparam int unsigned RAND_ITEMS = 120;
  localparam int unsigned DRAIN_WAIT = 100;

  typedef logic signed [KeyWidth-1:0] key_t;

  typedef struct packed {
    status_e status;
    key_t    key;
    logic    last;
  } set_result_t;

  typedef struct packed {
    op_e     op;
    key_t    key;
    logic    typed;
    status_e status;
  } dir_row_t;

  localparam key_t KEY_MIN = 32'sh8000_0000;
  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  op_e  op_in;
  key_t key_in;
  logic out_valid;
  logic out_ready;
  logic [StatusWidth-1:0] status_out;
  key_t out_key;
  logic last_out;

  // shadow copy of the set
  key_t        set_keys [CAPACITY];
  int          set_count;
  set_result_t fresh_results[$];
  set_result_t pending_results[$];

  int          send_idle_pct;
  int          stall_pct;
  int          hold_off_cycles;
  int unsigned fail_count;
  int unsigned cycle_count;
  logic        grow_mode;

  // directed rows; typed expectation where it is obvious, else the shadow set decides
  dir_row_t dir_rows [25] = '{
    '{OP_LIST_ASC,  32'sd0,          1'b1, ST_EMPTY},
    '{OP_LIST_DESC, -32'sd1,         1'b1, ST_EMPTY},
    '{OP_DELETE,    KEY_MIN,         1'b1, ST_EMPTY},
    '{OP_INSERT,    KEY_MAX,         1'b1, ST_OK},
    '{OP_INSERT,    KEY_MIN,         1'b1, ST_OK},
    '{OP_DELETE,    32'sd0,          1'b1, ST_NOT_FOUND},
    '{OP_INSERT,    32'sd0,          1'b0, ST_OK},
    '{OP_INSERT,    -32'sd1,         1'b0, ST_OK},
    '{OP_INSERT,    32'sd1,          1'b0, ST_OK},
    '{OP_INSERT,    32'sd100,        1'b0, ST_OK},
    '{OP_INSERT,    -32'sd100,       1'b0, ST_OK},
    '{OP_INSERT,    32'sh4000_0000,  1'b0, ST_OK},
    '{OP_INSERT,    32'shC000_0000,  1'b0, ST_OK},
    '{OP_INSERT,    32'sh7FFF_FFFE,  1'b0, ST_OK},
    '{OP_INSERT,    32'sh8000_0001,  1'b0, ST_OK},
    '{OP_INSERT,    32'sh5555_5555,  1'b0, ST_OK},
    '{OP_INSERT,    32'shAAAA_AAAA,  1'b0, ST_OK},
    '{OP_INSERT,    32'sd3,          1'b0, ST_OK},
    '{OP_INSERT,    -32'sd3,         1'b0, ST_OK},
    '{OP_INSERT,    32'sh1234_5678,  1'b0, ST_OK},
    '{OP_INSERT,    32'sd7,          1'b1, ST_FULL},
    '{OP_INSERT,    KEY_MIN,         1'b1, ST_DUP},
    '{OP_LIST_ASC,  32'sd5,          1'b0, ST_OK},
    '{OP_LIST_DESC, 32'sd5,          1'b0, ST_OK},
    '{OP_DELETE,    KEY_MAX,         1'b1, ST_OK}
  };

  sorted_key_set_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .op_i       (op_in),
    .key_i      (key_in),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status_out),
    .out_key_o  (out_key),
    .last_o     (last_out)
  );

  always #10 clk = ~clk;

  // Applies one operation to the shadow set and leaves its results in fresh_results.
  task automatic apply_to_set(input op_e op, input key_t key);
    int pos;
    int i;
    fresh_results.delete();
    case (op)
      OP_INSERT: begin
        pos = 0;
        while (pos < set_count && set_keys[pos] < key) pos++;
        if (pos < set_count && set_keys[pos] == key) begin
          fresh_results.push_back('{ST_DUP, key, 1'b1});
        end else if (set_count >= CAPACITY) begin
          fresh_results.push_back('{ST_FULL, key, 1'b1});
        end else begin
          for (i = set_count; i > pos; i--) set_keys[i] = set_keys[i-1];
          set_keys[pos] = key;
          set_count++;
          fresh_results.push_back('{ST_OK, key, 1'b1});
        end
      end
      OP_DELETE: begin
        pos = 0;
        while (pos < set_count && set_keys[pos] != key) pos++;
        if (set_count == 0) begin
          fresh_results.push_back('{ST_EMPTY, key, 1'b1});
        end else if (pos >= set_count) begin
          fresh_results.push_back('{ST_NOT_FOUND, key, 1'b1});
        end else begin
          for (i = pos; i + 1 < set_count; i++) set_keys[i] = set_keys[i+1];
          set_count--;
          fresh_results.push_back('{ST_OK, key, 1'b1});
        end
      end
      default: begin
        if (set_count == 0) begin
          fresh_results.push_back('{ST_EMPTY, key_t'(0), 1'b1});
        end else begin
          for (i = 0; i < set_count; i++) begin
            fresh_results.push_back('{ST_OK,
                                      set_keys[(op == OP_LIST_ASC) ? i : set_count - 1 - i],
                                      logic'(i + 1 == set_count)});
          end
        end
      end
    endcase
  endtask

  // Offers one item, waits for the transfer, then books the expected results.
  task automatic send_item(input op_e op, input key_t key, input logic typed,
                           input status_e status);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op_in    <= op;
    key_in   <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_to_set(op, key);
    if (typed) begin
      pending_results.push_back('{status,
                                  (op == OP_LIST_ASC || op == OP_LIST_DESC) ? key_t'(0) : key,
                                  1'b1});
    end else begin
      foreach (fresh_results[j]) pending_results.push_back(fresh_results[j]);
    end
  endtask

  // Mostly keys already stored or near them, so duplicates and hits are common.
  task automatic send_random_item();
    int   pick;
    op_e  op;
    key_t key;
    if (set_count == CAPACITY) grow_mode = 1'b0;
    if (set_count == 0)        grow_mode = 1'b1;
    pick = $urandom_range(99);
    if (grow_mode) begin
      op = (pick < 55) ? OP_INSERT : (pick < 80) ? OP_DELETE :
           (pick < 90) ? OP_LIST_ASC : OP_LIST_DESC;
    end else begin
      op = (pick < 20) ? OP_INSERT : (pick < 75) ? OP_DELETE :
           (pick < 88) ? OP_LIST_ASC : OP_LIST_DESC;
    end
    pick = $urandom_range(9);
    if (pick < 5 && set_count != 0) begin
      key = set_keys[$urandom_range(set_count - 1)];
    end else if (pick < 8) begin
      key = key_t'($urandom_range(40)) - 32'sd20;
    end else if (pick == 8) begin
      case ($urandom_range(3))
        0: key = KEY_MIN;
        1: key = KEY_MIN + 32'sd1;
        2: key = KEY_MAX;
        default: key = KEY_MAX - 32'sd1;
      endcase
    end else begin
      key = key_t'($urandom);
    end
    send_item(op, key, 1'b0, ST_OK);
  endtask

  // drop valid after the last transfer, then wait for every booked result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles != 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker
  set_result_t exp_res;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d key %0d last %0d",
               status_out, out_key, last_out);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (status_out !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, status_out);
          fail_count++;
        end
        if (out_key !== exp_res.key) begin
          $error("out_key: expected %0d, actual %0d", exp_res.key, out_key);
          fail_count++;
        end
        if (last_out !== exp_res.last) begin
          $error("last: expected %0d, actual %0d", exp_res.last, last_out);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int idle_set  [4];
    int stall_set [4];
    idle_set  = '{0, 77, 0, 26};
    stall_set = '{0, 0, 77, 26};
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    op_in           = OP_INSERT;
    key_in          = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_off_cycles = 0;
    fail_count      = 0;
    set_count       = 0;
    grow_mode       = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].op, dir_rows[r].key, dir_rows[r].typed, dir_rows[r].status);
    end
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      repeat (RAND_ITEMS) send_random_item();
      wait_drained();
    end

    // long receiver hold-off with the sender pushing back to back
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_off_cycles = 400;
    repeat (20) send_random_item();
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
